/* design/tkl_pkg.sv */
// Shared types and constants for the top-K longest list block.
package tkl_pkg;

    localparam int ID_W = 16;
    localparam int LEN_W = 16;
    localparam int RANK_W = 4;
    localparam int KEEP_W = 4;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 4'd10;

    localparam logic KIND_OFFER = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [ID_W-1:0]  entry_id;
        logic [LEN_W-1:0] entry_length;
    } in_beat_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [ID_W-1:0]   out_id;
        logic [LEN_W-1:0]  out_length;
        logic              last;
    } out_beat_t;

    typedef struct packed {
        logic insert;
        logic start_flush;
        logic shift;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic last_one;
    } status_t;

endpackage

/* design/tkl_ctrl.sv */
// Controller state machine: accepts beats and sequences the flush.
module tkl_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_kind,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  tkl_pkg::status_t  status,
    output tkl_pkg::cmd_t     cmd
);

    typedef enum logic {ST_IDLE, ST_FLUSH} state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;
    logic   out_fire;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_FLUSH);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd.insert      = 1'b0;
        cmd.start_flush = 1'b0;
        cmd.shift       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_kind == tkl_pkg::KIND_OFFER)
                    begin
                        cmd.insert = 1'b1;
                    end
                    else if (!status.empty)
                    begin
                        cmd.start_flush = 1'b1;
                        state_next      = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_fire)
                begin
                    cmd.shift = 1'b1;
                    if (status.last_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/tkl_dp.sv */
// Datapath: ranked compare-and-shift cells, fill count, keep count and rank counter.
module tkl_dp
#(
    parameter int TOP_K = 10
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tkl_pkg::cmd_t               cmd,
    output tkl_pkg::status_t            status,
    input  tkl_pkg::in_beat_t           in_data,
    input  logic                        cfg_we,
    input  logic [tkl_pkg::KEEP_W-1:0]  cfg_wdata,
    output tkl_pkg::out_beat_t          out_data
);

    localparam int CW = $clog2(TOP_K + 1);

    logic [tkl_pkg::LEN_W-1:0] len_reg [TOP_K];
    logic [tkl_pkg::LEN_W-1:0] len_next [TOP_K];
    logic [tkl_pkg::ID_W-1:0]  id_reg [TOP_K];
    logic [tkl_pkg::ID_W-1:0]  id_next [TOP_K];
    logic [TOP_K-1:0]          ins;

    logic [tkl_pkg::KEEP_W-1:0] keep_reg;
    logic [CW-1:0]              fill_reg;
    logic [CW-1:0]              fill_next;
    logic [CW-1:0]              rank_reg;
    logic [CW-1:0]              rank_next;
    logic [CW-1:0]              k_cur;
    logic [CW-1:0]              k_wr;

    function automatic logic [CW-1:0] clamp_k(input logic [tkl_pkg::KEEP_W-1:0] v);
        logic [CW-1:0] r;
        if (v == '0)
        begin
            r = CW'(1);
        end
        else if (32'(v) > TOP_K)
        begin
            r = CW'(TOP_K);
        end
        else
        begin
            r = CW'(v);
        end
        return r;
    endfunction

    assign k_cur = clamp_k(keep_reg);
    assign k_wr  = clamp_k(cfg_wdata);

    // Stored lengths are descending, so the cells the offer exceeds form a tail.
    always_comb
    begin
        for (int i = 0; i < TOP_K; i++)
        begin
            ins[i] = ((CW'(i) < fill_reg) && (in_data.entry_length > len_reg[i]))
                     || (CW'(i) == fill_reg);
        end
    end

    always_comb
    begin
        logic prev;
        prev = 1'b0;
        for (int i = 0; i < TOP_K; i++)
        begin
            len_next[i] = len_reg[i];
            id_next[i]  = id_reg[i];
            if (cmd.insert && ins[i])
            begin
                if (!prev)
                begin
                    len_next[i] = in_data.entry_length;
                    id_next[i]  = in_data.entry_id;
                end
                else
                begin
                    len_next[i] = len_reg[i-1];
                    id_next[i]  = id_reg[i-1];
                end
            end
            else if (cmd.shift && (i < TOP_K - 1))
            begin
                len_next[i] = len_reg[i+1];
                id_next[i]  = id_reg[i+1];
            end
            prev = ins[i];
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        rank_next = rank_reg;
        priority if (cfg_we)
        begin
            fill_next = (fill_reg > k_wr) ? k_wr : fill_reg;
        end
        else if (cmd.insert)
        begin
            if (fill_reg < k_cur)
            begin
                fill_next = fill_reg + CW'(1);
            end
        end
        else if (cmd.start_flush)
        begin
            rank_next = '0;
        end
        else if (cmd.shift)
        begin
            fill_next = fill_reg - CW'(1);
            rank_next = rank_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg <= tkl_pkg::KEEP_RESET;
            fill_reg <= '0;
            rank_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                keep_reg <= cfg_wdata;
            end
            fill_reg <= fill_next;
            rank_reg <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TOP_K; i++)
        begin
            len_reg[i] <= len_next[i];
            id_reg[i]  <= id_next[i];
        end
    end

    assign status.empty    = (fill_reg == '0);
    assign status.last_one = (fill_reg == CW'(1));

    assign out_data.rank       = tkl_pkg::RANK_W'(rank_reg);
    assign out_data.out_id     = id_reg[0];
    assign out_data.out_length = len_reg[0];
    assign out_data.last       = status.last_one;

endmodule

/* design/top_k_longest_list_top.sv */
// Top level of the top-K longest list: controller and datapath.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    tkl_pkg::in_beat_t
// out       output     out_valid / out_ready  tkl_pkg::out_beat_t
// cfg       input      cfg_we                 keep_count (4 bits)
//
// On an offer beat every cell compares the offered length with
// its own entry in parallel and the list shifts down behind the insertion
// point in the same clock edge. A flush beat then yields one result beat per
// stored entry; each taken result shifts the list up by one, so rank 0 is
// always read from the head cell. Input is not taken while a flush drains.
// Reset clears the fill count and loads keep_count with 10; the cells need no
// clearing. A stalled out_ready simply holds the current result beat.
module top_k_longest_list_top
#(
    parameter int TOP_K = 10
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tkl_pkg::in_beat_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tkl_pkg::out_beat_t          out_data,
    input  logic                        cfg_we,
    input  logic [tkl_pkg::KEEP_W-1:0]  cfg_wdata
);

    tkl_pkg::cmd_t    cmd;
    tkl_pkg::status_t status;

    // The controller only sees the handshakes, the beat kind and the fill status.
    tkl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_kind   (in_data.kind),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the ranked cells, keep_count and the counters.
    tkl_dp #(.TOP_K(TOP_K)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_data  (out_data)
    );

    // Input and output beats never overlap: a flush blocks new input.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while a flush drains");

    // The final result beat of a flush returns the block to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.last) |=> (!out_valid && in_ready))
        else $error("flush did not end after its last beat");

    // Inside a flush the rank steps by one per taken beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.last) |=>
        (out_valid && (out_data.rank == $past(out_data.rank) + 4'd1)))
        else $error("flush rank did not advance");

endmodule
